@@ hw/rtl/dns_nxdomain_reply_builder_top_assert.svh @@
// ----------------------------------------------------------------------------
// DNS NXDOMAIN reply builder assertion macros
// Shared concurrent assertion forms used by the reply builder modules.
// ----------------------------------------------------------------------------
`ifndef DNS_NXDOMAIN_REPLY_BUILDER_TOP_ASSERT_SVH
`define DNS_NXDOMAIN_REPLY_BUILDER_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define DNR_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define DNR_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dnr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS NXDOMAIN reply builder package
// Types and constants shared by the reply builder modules and interfaces.
// ----------------------------------------------------------------------------
package dnr_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t HDR_LEN = 8'd12;
  localparam byte_t OFFSET_MAX = 8'd255;
  localparam logic [8:0] MAX_QUERY_LEN = 9'd192;
  localparam byte_t LABEL_TYPE_MASK = 8'hC0;
  localparam byte_t RCODE_NXDOMAIN = 8'h03;
  localparam logic [2:0] TAIL_LEN = 3'd4;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LEN    = 5'b00010,
    PH_BODY   = 5'b00100,
    PH_TAIL   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  typedef struct packed {
    byte_t out_byte;
    logic  out_keep;
    logic  out_last;
    logic  send_reply;
    byte_t reply_length;
  } result_t;

endpackage

@@ hw/rtl/dnr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS NXDOMAIN reply builder channels
// Valid/ready channels for query bytes in and reply bytes out.
// ----------------------------------------------------------------------------
interface dnr_in_if;
  logic           valid;
  logic           ready;
  dnr_pkg::byte_t in_byte;
  logic           in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface dnr_out_if;
  logic           valid;
  logic           ready;
  dnr_pkg::byte_t out_byte;
  logic           out_keep;
  logic           out_last;
  logic           send_reply;
  dnr_pkg::byte_t reply_length;

  modport source (output valid, output out_byte, output out_keep, output out_last,
                  output send_reply, output reply_length, input ready);
  modport sink (input valid, input out_byte, input out_keep, input out_last,
                input send_reply, input reply_length, output ready);
endinterface

@@ hw/rtl/dnr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS NXDOMAIN reply builder parser core
// Holds the per-packet parse state and forms one reply item per query byte.
// ----------------------------------------------------------------------------
module dnr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  dnr_pkg::byte_t   in_byte,
  input  logic             in_last,
  output dnr_pkg::result_t res
);
  import dnr_pkg::*;

  byte_t      off_r, off_nxt;
  logic       qp_r, qp_nxt;
  phase_t     phase_r, phase_nxt;
  logic [5:0] label_left_r, label_left_nxt;
  logic [2:0] tail_left_r, tail_left_nxt;
  byte_t      qend_r, qend_nxt;
  logic       mal_r, mal_nxt;

  byte_t      ob;
  logic       keep;
  logic [8:0] len;
  logic       ok;

  always_comb begin
    ob             = in_byte;
    keep           = 1'b0;
    qp_nxt         = qp_r;
    phase_nxt      = phase_r;
    label_left_nxt = label_left_r;
    tail_left_nxt  = tail_left_r;
    qend_nxt       = qend_r;
    mal_nxt        = mal_r;
    unique case (phase_r)
      PH_HEADER: begin
        if (off_r < HDR_LEN) begin
          keep = 1'b1;
          if (off_r == 8'd2) begin
            ob = {1'b1, 6'd0, in_byte[0]};
          end else if (off_r == 8'd3) begin
            ob = RCODE_NXDOMAIN;
          end else if (off_r >= 8'd6) begin
            ob = 8'd0;
          end
          if ((off_r == 8'd4 || off_r == 8'd5) && in_byte != 8'd0) begin
            qp_nxt = 1'b1;
          end
          if (off_r == HDR_LEN - 8'd1) begin
            if (qp_nxt) begin
              phase_nxt = PH_LEN;
            end else begin
              phase_nxt = PH_DONE;
              qend_nxt  = HDR_LEN;
            end
          end
        end
      end
      PH_LEN: begin
        if (in_byte == 8'd0) begin
          keep          = 1'b1;
          tail_left_nxt = TAIL_LEN;
          phase_nxt     = PH_TAIL;
        end else if ((in_byte & LABEL_TYPE_MASK) != 8'd0) begin
          mal_nxt   = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          keep           = 1'b1;
          label_left_nxt = in_byte[5:0];
          phase_nxt      = PH_BODY;
        end
      end
      PH_BODY: begin
        keep           = 1'b1;
        label_left_nxt = label_left_r - 6'd1;
        if (label_left_nxt == 6'd0) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_TAIL: begin
        keep          = 1'b1;
        tail_left_nxt = tail_left_r - 3'd1;
        if (tail_left_nxt == 3'd0) begin
          qend_nxt  = (off_r != OFFSET_MAX) ? off_r + 8'd1 : OFFSET_MAX;
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    len = {1'b0, off_r} + 9'd1;
    ok  = !mal_nxt && (phase_nxt == PH_DONE) && (len >= {1'b0, HDR_LEN}) &&
          (len <= MAX_QUERY_LEN) && ({1'b0, qend_nxt} <= len);

    res.out_byte     = ob;
    res.out_keep     = keep;
    res.out_last     = in_last;
    res.send_reply   = in_last && ok;
    res.reply_length = (in_last && ok) ? qend_nxt : 8'd0;

    if (in_last) begin
      off_nxt        = 8'd0;
      qp_nxt         = 1'b0;
      phase_nxt      = PH_HEADER;
      label_left_nxt = 6'd0;
      tail_left_nxt  = 3'd0;
      qend_nxt       = HDR_LEN;
      mal_nxt        = 1'b0;
    end else begin
      off_nxt = (off_r != OFFSET_MAX) ? off_r + 8'd1 : off_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r        <= 8'd0;
      qp_r         <= 1'b0;
      phase_r      <= PH_HEADER;
      label_left_r <= 6'd0;
      tail_left_r  <= 3'd0;
      qend_r       <= HDR_LEN;
      mal_r        <= 1'b0;
    end else if (en) begin
      off_r        <= off_nxt;
      qp_r         <= qp_nxt;
      phase_r      <= phase_nxt;
      label_left_r <= label_left_nxt;
      tail_left_r  <= tail_left_nxt;
      qend_r       <= qend_nxt;
      mal_r        <= mal_nxt;
    end
  end

  `include "dns_nxdomain_reply_builder_top_assert.svh"

  `DNR_ASSERT_NEXT(a_last_clears_offset, en && in_last, off_r == 8'd0,
                   "offset not cleared after final byte")
  `DNR_ASSERT_NOW(a_body_has_count, phase_r == PH_BODY, label_left_r != 6'd0,
                  "label body entered with zero count")
  `DNR_ASSERT_NOW(a_tail_has_count, phase_r == PH_TAIL, tail_left_r != 3'd0,
                  "tail entered with zero count")
endmodule

@@ hw/rtl/dns_nxdomain_reply_builder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS NXDOMAIN reply builder
// Rewrites a DNS query into an NXDOMAIN reply header and decides send or drop.
// ----------------------------------------------------------------------------
// Query bytes enter on in_ch, one item per byte, with in_last on the final
// byte of the payload. Each accepted item yields exactly one item on out_ch
// carrying the reply byte at the same offset, a keep flag for header and
// question bytes, and on the final byte the send verdict and reply length.
// An item passes an input register and then a result register before its
// result is on out_ch, where the receiver can take it. One item is accepted
// every cycle while out_ch keeps up; the rate is set by the parse state
// update between the two registers.
// When out_ch stalls, the result register holds its item and the input
// register still takes one more byte; after that in_ch.ready drops until the
// receiver takes the waiting result.
// Synchronous reset empties both registers and returns the parser to the
// start of a packet; the block takes items in the first cycle after reset.
// ----------------------------------------------------------------------------
module dns_nxdomain_reply_builder_top (
  input logic      clk,
  input logic      rst_n,
  dnr_in_if.sink   in_ch,
  dnr_out_if.source out_ch
);
  import dnr_pkg::*;

  logic    s1_valid_r, s1_valid_nxt;
  byte_t   s1_byte_r;
  logic    s1_last_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;
  result_t res;
  logic    adv;
  logic    in_acc;

  assign adv    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  dnr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_byte (s1_byte_r),
    .in_last (s1_last_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.in_byte;
      s1_last_r <= in_ch.in_last;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_r.out_byte;
  assign out_ch.out_keep     = out_r.out_keep;
  assign out_ch.out_last     = out_r.out_last;
  assign out_ch.send_reply   = out_r.send_reply;
  assign out_ch.reply_length = out_r.reply_length;

  `include "dns_nxdomain_reply_builder_top_assert.svh"

  `DNR_ASSERT_NOW(a_send_on_last, out_valid_r && out_r.send_reply, out_r.out_last,
                  "send verdict on a byte that is not the final one")
  `DNR_ASSERT_NOW(a_len_range, out_valid_r && out_r.send_reply,
                  (out_r.reply_length >= HDR_LEN &&
                   ({1'b0, out_r.reply_length} <= MAX_QUERY_LEN)),
                  "reply length out of range")
  `DNR_ASSERT_NOW(a_drop_len_zero, out_valid_r && !out_r.send_reply,
                  out_r.reply_length == 8'd0, "nonzero length on dropped query")
endmodule
